// ===== hw/rtl/spfsa_pkg.sv =====
// Shared types and constants for the slot page free stack allocator.
package spfsa_pkg;

   // Page geometry.
   localparam int MAX_SLOTS    = 256;
   localparam int HEADER_BYTES = 32;

   // Field and register widths.
   localparam int OFFSET_W = 12;
   localparam int SIZE_W   = 13;
   localparam int COUNT_W  = 9;
   localparam int SLOT_W   = 8;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_BYTES = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_TOTAL = 1'd1;

   // Request function codes.
   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   // Divider: one quotient bit per step over the whole offset.
   localparam int DIV_STEPS = OFFSET_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POP,
      ST_MUL,
      ST_DIV,
      ST_PUSH,
      ST_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load_req;
      logic check;
      logic pop;
      logic mul;
      logic div_step;
      logic push;
      logic rsp_load;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic is_free;
      logic fail;
      logic rsp_open;
   } status_type;

endpackage

// ===== hw/rtl/slot_page_free_stack_allocator_top.sv =====
// Top level of the slot page free stack allocator.
//
//   Channel | Ports                                 | Direction
//   req     | req_valid/req_stall, func/offset/size | in
//   rsp     | rsp_valid/rsp_stall, offset and flags | out
//   csr     | csr_write_en, csr_index, csr_wdata    | in
//
// An allocate passes from accept through check, stack read, multiply and
// output load; a refused request goes from the check to the output load. A free
// runs the 12-step bit-serial divider and then the stack push.
// Reset is synchronous and empties the stack; the stack memory needs no clear.
// A new request is taken while a finished beat still waits on rsp_stall.
module slot_page_free_stack_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [spfsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spfsa_pkg::SIZE_W-1:0]    csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [spfsa_pkg::OFFSET_W-1:0]  req_page_offset,
   input  logic [spfsa_pkg::SIZE_W-1:0]    req_data_size,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [spfsa_pkg::OFFSET_W-1:0]  rsp_slot_offset,
   output logic                            rsp_no_space,
   output logic                            rsp_size_error,
   output logic                            rsp_remove_error,
   output logic [spfsa_pkg::COUNT_W-1:0]   rsp_free_slots
);
   import spfsa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   spfsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Registers, stack, divider and multiplier.
   spfsa_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_func         (req_func),
      .req_page_offset  (req_page_offset),
      .req_data_size    (req_data_size),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot_offset  (rsp_slot_offset),
      .rsp_no_space     (rsp_no_space),
      .rsp_size_error   (rsp_size_error),
      .rsp_remove_error (rsp_remove_error),
      .rsp_free_slots   (rsp_free_slots),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

// ===== hw/rtl/spfsa_ctrl.sv =====
// Controller state machine of the slot page free stack allocator.
module spfsa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  spfsa_pkg::status_type status,
   output spfsa_pkg::cmd_type    cmd
);
   import spfsa_pkg::*;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Flags are latched here; the divider is loaded as well.
            cmd.check = 1'b1;
            cnt_in    = '0;
            if (status.fail) begin
               state_in = ST_DONE;
            end else if (status.is_free) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop  = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_PUSH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // Wait until the output register can take the beat.
            if (status.rsp_open) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/spfsa_dp.sv =====
// Datapath of the slot page free stack allocator: registers, stack, divider, multiplier.
module spfsa_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [spfsa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spfsa_pkg::SIZE_W-1:0]          csr_wdata,
   input  logic                                  req_func,
   input  logic [spfsa_pkg::OFFSET_W-1:0]        req_page_offset,
   input  logic [spfsa_pkg::SIZE_W-1:0]          req_data_size,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [spfsa_pkg::OFFSET_W-1:0]        rsp_slot_offset,
   output logic                                  rsp_no_space,
   output logic                                  rsp_size_error,
   output logic                                  rsp_remove_error,
   output logic [spfsa_pkg::COUNT_W-1:0]         rsp_free_slots,
   input  spfsa_pkg::cmd_type                    cmd,
   output spfsa_pkg::status_type                 status
);
   import spfsa_pkg::*;

   // Configuration registers.
   logic [SIZE_W-1:0]   slot_bytes_ff, slot_bytes_in;
   logic [COUNT_W-1:0]  slot_total_ff, slot_total_in;
   // Captured request.
   logic                func_ff, func_in;
   logic [OFFSET_W-1:0] page_offset_ff, page_offset_in;
   logic [SIZE_W-1:0]   data_size_ff, data_size_in;
   // Stack pointer and stack memory.
   logic [COUNT_W-1:0]  free_count_ff, free_count_in;
   logic [SLOT_W-1:0]   stack_mem [MAX_SLOTS];
   logic [SLOT_W-1:0]   rd_data_ff;
   // Divider: partial remainder and dividend/quotient shift register.
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [OFFSET_W-1:0] quo_ff, quo_in;
   // Result being built.
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic                no_space_ff, no_space_in;
   logic                size_err_ff, size_err_in;
   logic                rm_err_ff, rm_err_in;
   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic                rsp_no_space_ff, rsp_no_space_in;
   logic                rsp_size_err_ff, rsp_size_err_in;
   logic                rsp_rm_err_ff, rsp_rm_err_in;
   logic [COUNT_W-1:0]  rsp_free_ff, rsp_free_in;

   logic [SIZE_W-1:0]          eff_bytes;
   logic [COUNT_W-1:0]         total_limit;
   logic                       size_chk;
   logic                       empty;
   logic                       full;
   logic [OFFSET_W-1:0]        body;
   logic [SIZE_W:0]            trial;
   logic                       trial_ge;
   logic [SIZE_W+SLOT_W-1:0]   product;
   logic [COUNT_W-1:0]         pop_count;

   // Checks on the captured request against the current state.
   always_comb begin
      eff_bytes   = (slot_bytes_ff == '0) ? SIZE_W'(1) : slot_bytes_ff;
      total_limit = (slot_total_ff > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                          : slot_total_ff;
      size_chk    = data_size_ff > slot_bytes_ff;
      empty       = free_count_ff == '0;
      full        = free_count_ff >= total_limit;
      body        = (page_offset_ff >= OFFSET_W'(HEADER_BYTES))
                    ? page_offset_ff - OFFSET_W'(HEADER_BYTES) : '0;
      trial       = {rem_ff, quo_ff[OFFSET_W-1]};
      trial_ge    = trial >= {1'b0, eff_bytes};
      product     = eff_bytes * rd_data_ff;
      pop_count   = free_count_ff - 1'b1;
   end

   assign status.is_free  = func_ff == FUNC_FREE;
   assign status.fail     = (func_ff == FUNC_FREE) ? full : (size_chk | empty);
   assign status.rsp_open = !rsp_valid_ff || !rsp_stall;

   // Next values of all datapath registers.
   always_comb begin
      slot_bytes_in   = slot_bytes_ff;
      slot_total_in   = slot_total_ff;
      func_in         = func_ff;
      page_offset_in  = page_offset_ff;
      data_size_in    = data_size_ff;
      free_count_in   = free_count_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      offset_in       = offset_ff;
      no_space_in     = no_space_ff;
      size_err_in     = size_err_ff;
      rm_err_in       = rm_err_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_offset_in   = rsp_offset_ff;
      rsp_no_space_in = rsp_no_space_ff;
      rsp_size_err_in = rsp_size_err_ff;
      rsp_rm_err_in   = rsp_rm_err_ff;
      rsp_free_in     = rsp_free_ff;

      // Configuration writes.
      if (csr_write_en) begin
         case (csr_index)
            CSR_SLOT_BYTES: slot_bytes_in = csr_wdata;
            CSR_SLOT_TOTAL: slot_total_in = csr_wdata[COUNT_W-1:0];
            default:        slot_bytes_in = slot_bytes_ff;
         endcase
      end

      if (cmd.load_req) begin
         func_in        = req_func;
         page_offset_in = req_page_offset;
         data_size_in   = req_data_size;
      end

      // Latch error flags and load the divider.
      if (cmd.check) begin
         offset_in   = '0;
         size_err_in = (func_ff == FUNC_ALLOC) && size_chk;
         no_space_in = (func_ff == FUNC_ALLOC) && !size_chk && empty;
         rm_err_in   = (func_ff == FUNC_FREE) && full;
         rem_in      = '0;
         quo_in      = body;
      end

      if (cmd.pop) begin
         free_count_in = pop_count;
      end

      // Offset of the popped slot, wrapped to the page offset width.
      if (cmd.mul) begin
         offset_in = OFFSET_W'(product + (SIZE_W+SLOT_W)'(HEADER_BYTES));
      end

      // One restoring division step.
      if (cmd.div_step) begin
         rem_in = trial_ge ? SIZE_W'(trial - {1'b0, eff_bytes}) : trial[SIZE_W-1:0];
         quo_in = {quo_ff[OFFSET_W-2:0], trial_ge};
      end

      if (cmd.push) begin
         free_count_in = free_count_ff + 1'b1;
      end

      if (cmd.rsp_load) begin
         rsp_valid_in    = 1'b1;
         rsp_offset_in   = offset_ff;
         rsp_no_space_in = no_space_ff;
         rsp_size_err_in = size_err_ff;
         rsp_rm_err_in   = rm_err_ff;
         rsp_free_in     = free_count_ff;
      end
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_bytes_ff <= SIZE_W'(1);
         slot_total_ff <= '0;
         free_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_bytes_ff <= slot_bytes_in;
         slot_total_ff <= slot_total_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      func_ff         <= func_in;
      page_offset_ff  <= page_offset_in;
      data_size_ff    <= data_size_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      offset_ff       <= offset_in;
      no_space_ff     <= no_space_in;
      size_err_ff     <= size_err_in;
      rm_err_ff       <= rm_err_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_no_space_ff <= rsp_no_space_in;
      rsp_size_err_ff <= rsp_size_err_in;
      rsp_rm_err_ff   <= rsp_rm_err_in;
      rsp_free_ff     <= rsp_free_in;
   end

   // Free slot stack: push writes at the count, pop reads just below it.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[free_count_ff[SLOT_W-1:0]] <= quo_ff[SLOT_W-1:0];
      end
      if (cmd.pop) begin
         rd_data_ff <= stack_mem[pop_count[SLOT_W-1:0]];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_slot_offset  = rsp_offset_ff;
   assign rsp_no_space     = rsp_no_space_ff;
   assign rsp_size_error   = rsp_size_err_ff;
   assign rsp_remove_error = rsp_rm_err_ff;
   assign rsp_free_slots   = rsp_free_ff;

endmodule
